### rtl/tgfr_pkg.sv
// Package: screen geometry, action codes, store port structs and the 5x7 font table.
package tgfr_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGES         = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_SIZE    = SCREEN_WIDTH * PAGES;
  localparam int COL_BITS      = $clog2(SCREEN_WIDTH);
  localparam int PAGE_BITS     = $clog2(PAGES);
  localparam int ADDR_BITS     = COL_BITS + PAGE_BITS;

  localparam int GLYPHS        = 95;
  localparam int GLYPH_COLS    = 5;
  localparam int X_LIMIT       = SCREEN_WIDTH - 6;

  localparam logic [7:0] CODE_FIRST = 8'd32;
  localparam logic [7:0] CODE_LAST  = 8'd126;
  localparam logic [7:0] CODE_SUB   = 8'd63;
  localparam logic [7:0] X_ADVANCE  = 8'd6;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_START = 2'd1,
    ACT_CHAR  = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           data;
  } store_wr_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
  } store_rd_t;

  localparam logic [7:0] FONT_ROM [GLYPHS][GLYPH_COLS] = '{
    '{8'd0,8'd0,8'd0,8'd0,8'd0},       '{8'd0,8'd0,8'd95,8'd0,8'd0},
    '{8'd0,8'd7,8'd0,8'd7,8'd0},       '{8'd20,8'd127,8'd20,8'd127,8'd20},
    '{8'd36,8'd42,8'd127,8'd42,8'd18}, '{8'd35,8'd19,8'd8,8'd100,8'd98},
    '{8'd54,8'd73,8'd85,8'd34,8'd80},  '{8'd0,8'd0,8'd7,8'd0,8'd0},
    '{8'd0,8'd28,8'd34,8'd65,8'd0},    '{8'd0,8'd65,8'd34,8'd28,8'd0},
    '{8'd20,8'd8,8'd62,8'd8,8'd20},    '{8'd8,8'd8,8'd62,8'd8,8'd8},
    '{8'd0,8'd80,8'd48,8'd0,8'd0},     '{8'd8,8'd8,8'd8,8'd8,8'd8},
    '{8'd0,8'd96,8'd96,8'd0,8'd0},     '{8'd32,8'd16,8'd8,8'd4,8'd2},
    '{8'd62,8'd81,8'd73,8'd69,8'd62},  '{8'd0,8'd66,8'd127,8'd64,8'd0},
    '{8'd66,8'd97,8'd81,8'd73,8'd70},  '{8'd33,8'd65,8'd69,8'd75,8'd49},
    '{8'd24,8'd20,8'd18,8'd127,8'd16}, '{8'd39,8'd69,8'd69,8'd69,8'd57},
    '{8'd60,8'd74,8'd73,8'd73,8'd48},  '{8'd1,8'd113,8'd9,8'd5,8'd3},
    '{8'd54,8'd73,8'd73,8'd73,8'd54},  '{8'd6,8'd73,8'd73,8'd41,8'd30},
    '{8'd0,8'd54,8'd54,8'd0,8'd0},     '{8'd0,8'd86,8'd54,8'd0,8'd0},
    '{8'd8,8'd20,8'd34,8'd65,8'd0},    '{8'd20,8'd20,8'd20,8'd20,8'd20},
    '{8'd65,8'd34,8'd20,8'd8,8'd0},    '{8'd2,8'd1,8'd81,8'd9,8'd6},
    '{8'd50,8'd73,8'd121,8'd65,8'd62}, '{8'd126,8'd17,8'd17,8'd17,8'd126},
    '{8'd127,8'd73,8'd73,8'd73,8'd54}, '{8'd62,8'd65,8'd65,8'd65,8'd34},
    '{8'd127,8'd65,8'd65,8'd34,8'd28}, '{8'd127,8'd73,8'd73,8'd65,8'd65},
    '{8'd127,8'd9,8'd9,8'd1,8'd1},     '{8'd62,8'd65,8'd73,8'd73,8'd122},
    '{8'd127,8'd8,8'd8,8'd8,8'd127},   '{8'd0,8'd65,8'd127,8'd65,8'd0},
    '{8'd32,8'd64,8'd65,8'd63,8'd1},   '{8'd127,8'd8,8'd20,8'd34,8'd65},
    '{8'd127,8'd64,8'd64,8'd64,8'd64}, '{8'd127,8'd2,8'd12,8'd2,8'd127},
    '{8'd127,8'd4,8'd8,8'd16,8'd127},  '{8'd62,8'd65,8'd65,8'd65,8'd62},
    '{8'd127,8'd9,8'd9,8'd9,8'd6},     '{8'd62,8'd65,8'd81,8'd33,8'd94},
    '{8'd127,8'd9,8'd25,8'd41,8'd70},  '{8'd38,8'd73,8'd73,8'd73,8'd50},
    '{8'd1,8'd1,8'd127,8'd1,8'd1},     '{8'd63,8'd64,8'd64,8'd64,8'd63},
    '{8'd31,8'd32,8'd64,8'd32,8'd31},  '{8'd127,8'd32,8'd24,8'd32,8'd127},
    '{8'd99,8'd20,8'd8,8'd20,8'd99},   '{8'd3,8'd4,8'd120,8'd4,8'd3},
    '{8'd97,8'd81,8'd73,8'd69,8'd67},  '{8'd0,8'd127,8'd65,8'd65,8'd0},
    '{8'd2,8'd4,8'd8,8'd16,8'd32},     '{8'd0,8'd65,8'd65,8'd127,8'd0},
    '{8'd4,8'd2,8'd1,8'd2,8'd4},       '{8'd64,8'd64,8'd64,8'd64,8'd64},
    '{8'd0,8'd3,8'd7,8'd0,8'd0},       '{8'd32,8'd84,8'd84,8'd84,8'd120},
    '{8'd127,8'd72,8'd68,8'd68,8'd56}, '{8'd56,8'd68,8'd68,8'd68,8'd32},
    '{8'd56,8'd68,8'd68,8'd72,8'd127}, '{8'd56,8'd84,8'd84,8'd84,8'd24},
    '{8'd8,8'd126,8'd9,8'd1,8'd2},     '{8'd12,8'd82,8'd82,8'd82,8'd62},
    '{8'd127,8'd8,8'd4,8'd4,8'd120},   '{8'd0,8'd68,8'd125,8'd64,8'd0},
    '{8'd32,8'd64,8'd68,8'd61,8'd0},   '{8'd127,8'd16,8'd40,8'd68,8'd0},
    '{8'd0,8'd65,8'd127,8'd64,8'd0},   '{8'd124,8'd4,8'd24,8'd4,8'd120},
    '{8'd124,8'd8,8'd4,8'd4,8'd120},   '{8'd56,8'd68,8'd68,8'd68,8'd56},
    '{8'd124,8'd20,8'd20,8'd20,8'd8},  '{8'd8,8'd20,8'd20,8'd24,8'd124},
    '{8'd124,8'd8,8'd4,8'd4,8'd8},     '{8'd72,8'd84,8'd84,8'd84,8'd36},
    '{8'd4,8'd63,8'd68,8'd64,8'd32},   '{8'd60,8'd64,8'd64,8'd32,8'd124},
    '{8'd28,8'd32,8'd64,8'd32,8'd28},  '{8'd60,8'd64,8'd48,8'd64,8'd60},
    '{8'd68,8'd40,8'd16,8'd40,8'd68},  '{8'd12,8'd80,8'd80,8'd80,8'd60},
    '{8'd68,8'd100,8'd84,8'd76,8'd68}, '{8'd0,8'd8,8'd54,8'd65,8'd0},
    '{8'd0,8'd0,8'd127,8'd0,8'd0},     '{8'd0,8'd65,8'd54,8'd8,8'd0},
    '{8'd8,8'd4,8'd8,8'd16,8'd8}
  };

  function automatic logic [7:0] glyph_column(logic [6:0] g, logic [2:0] c);
    logic [7:0] v;
    v = '0;
    if (g < 7'(GLYPHS) && c < 3'(GLYPH_COLS)) begin
      v = FONT_ROM[g][c];
    end
    return v;
  endfunction

endpackage

### rtl/tgfr_store.sv
// Page-byte framebuffer memory: one write port, one registered read port.
module tgfr_store (
  input  logic                clk,
  input  tgfr_pkg::store_wr_t wr,
  input  tgfr_pkg::store_rd_t rd,
  output logic [7:0]          rd_data
);
  import tgfr_pkg::*;

  logic [7:0] mem [STORE_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

### rtl/text_glyph_framebuffer_renderer.sv
// Top level: 5x7 text renderer over a page-organized monochrome framebuffer.
//
//  channel | dir | handshake           | payload
//  in_     | in  | in_tvalid/in_tready | action, start_x, start_y, char_code, byte_index
//  out_    | out | out_tvalid/out_tready | pixel_byte, read_index
//
//  Start text: loads the cursor in S_IDLE. Read: a registered store read into S_RDOUT, plus any wait on a held result.
//  Draw character: ten read-modify-write passes (S_GREAD then S_GWRITE per page byte)
//  through one shifter and the single memory port pair.
//  Clear: one byte per cycle. After reset the same sweep runs
//  with in_tready low.
//  A pending result does not block new transactions unless another read arrives.
module text_glyph_framebuffer_renderer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // action[1:0], start_x[9:2], start_y[17:10], char_code[25:18], byte_index[35:26]
  input  logic [tgfr_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // pixel_byte[7:0], read_index[17:8]
  output logic [tgfr_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tgfr_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RDOUT,
    S_GREAD,
    S_GWRITE
  } state_t;

  state_t               state_r, state_nxt;
  logic [ADDR_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [7:0]           cursor_x_r, cursor_x_nxt;
  logic [7:0]           cursor_y_r, cursor_y_nxt;
  logic                 active_r, active_nxt;
  logic [6:0]           glyph_r, glyph_nxt;
  logic [2:0]           col_r, col_nxt;
  logic                 half_r, half_nxt;
  logic [9:0]           rd_index_r, rd_index_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_pixel_r, out_pixel_nxt;
  logic [9:0]           out_index_r, out_index_nxt;

  action_t              in_action;
  logic [7:0]           in_start_x;
  logic [7:0]           in_start_y;
  logic [7:0]           in_char_code;
  logic [9:0]           in_byte_index;
  logic                 in_fire;

  logic [7:0]           font_col;
  logic [15:0]          shifted;
  logic [5:0]           page;
  logic                 page_ok;
  logic [7:0]           px;
  logic [ADDR_BITS-1:0] g_addr;
  logic [7:0]           g_mask;
  logic [7:0]           code_sel;

  store_wr_t            st_wr;
  store_rd_t            st_rd;
  logic [7:0]           st_rd_data;

  tgfr_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd      (st_rd),
    .rd_data (st_rd_data)
  );

  assign in_action     = action_t'(in_tdata[1:0]);
  assign in_start_x    = in_tdata[9:2];
  assign in_start_y    = in_tdata[17:10];
  assign in_char_code  = in_tdata[25:18];
  assign in_byte_index = in_tdata[35:26];

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_index_r, out_pixel_r};

  assign font_col = glyph_column(glyph_r, col_r);
  assign shifted  = {9'd0, font_col[6:0]} << cursor_y_r[2:0];
  assign page     = {1'b0, cursor_y_r[7:3]} + {5'd0, half_r};
  assign page_ok  = page < 6'(PAGES);
  assign px       = cursor_x_r + {5'd0, col_r};
  assign g_addr   = {page[PAGE_BITS-1:0], px[COL_BITS-1:0]};
  assign g_mask   = half_r ? shifted[15:8] : shifted[7:0];

  always_comb begin
    if (in_char_code < CODE_FIRST || in_char_code > CODE_LAST) begin
      code_sel = CODE_SUB - CODE_FIRST;
    end else begin
      code_sel = in_char_code - CODE_FIRST;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    cursor_x_nxt  = cursor_x_r;
    cursor_y_nxt  = cursor_y_r;
    active_nxt    = active_r;
    glyph_nxt     = glyph_r;
    col_nxt       = col_r;
    half_nxt      = half_r;
    rd_index_nxt  = rd_index_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pixel_nxt = out_pixel_r;
    out_index_nxt = out_index_r;
    st_wr         = '0;
    st_rd         = '0;
    case (state_r)
      S_CLEAR: begin
        st_wr.en     = 1'b1;
        st_wr.addr   = clr_addr_r;
        st_wr.data   = 8'd0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            ACT_START: begin
              cursor_x_nxt = in_start_x;
              cursor_y_nxt = in_start_y;
              active_nxt   = 1'b1;
            end
            ACT_CHAR: begin
              if (active_r) begin
                if (in_char_code == 8'd0 || cursor_x_r > 8'(X_LIMIT)) begin
                  active_nxt = 1'b0;
                end else begin
                  glyph_nxt = code_sel[6:0];
                  col_nxt   = 3'd0;
                  half_nxt  = 1'b0;
                  state_nxt = S_GREAD;
                end
              end
            end
            ACT_READ: begin
              st_rd.en     = 1'b1;
              st_rd.addr   = ADDR_BITS'(in_byte_index);
              rd_index_nxt = in_byte_index;
              state_nxt    = S_RDOUT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_RDOUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_pixel_nxt = st_rd_data;
          out_index_nxt = rd_index_r;
          state_nxt     = S_IDLE;
        end
      end
      S_GREAD: begin
        st_rd.en   = 1'b1;
        st_rd.addr = g_addr;
        state_nxt  = S_GWRITE;
      end
      S_GWRITE: begin
        st_wr.en   = page_ok;
        st_wr.addr = g_addr;
        st_wr.data = st_rd_data | g_mask;
        if (!half_r) begin
          half_nxt  = 1'b1;
          state_nxt = S_GREAD;
        end else begin
          half_nxt = 1'b0;
          if (col_r == 3'(GLYPH_COLS - 1)) begin
            cursor_x_nxt = cursor_x_r + X_ADVANCE;
            state_nxt    = S_IDLE;
          end else begin
            col_nxt   = col_r + 3'd1;
            state_nxt = S_GREAD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cursor_x_r  <= 8'd0;
      cursor_y_r  <= 8'd0;
      active_r    <= 1'b0;
      col_r       <= 3'd0;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      cursor_x_r  <= cursor_x_nxt;
      cursor_y_r  <= cursor_y_nxt;
      active_r    <= active_nxt;
      col_r       <= col_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
    glyph_r     <= glyph_nxt;
    rd_index_r  <= rd_index_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_index_r <= out_index_nxt;
  end

`ifndef NO_ASSERTIONS
  a_clear_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (st_wr.en && st_wr.data == 8'd0))
    else $error("clear sweep not writing zero");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GREAD || state_r == S_GWRITE) |-> (col_r < 3'(GLYPH_COLS)))
    else $error("glyph column out of range");

  a_read_goes_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_action == ACT_READ) |=> (state_r == S_RDOUT))
    else $error("read transaction did not reach output stage");

  a_cursor_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GWRITE && half_r && col_r == 3'(GLYPH_COLS - 1))
      |=> (cursor_x_r == $past(cursor_x_r) + X_ADVANCE))
    else $error("cursor did not advance after glyph");
`endif

endmodule

### tb/tgfr_render_checker.sv
// Checker: shadow framebuffer and cursor, predicts read results and compares the out_ channel.
module tgfr_render_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [tgfr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [tgfr_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              mismatches,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tgfr_pkg::*;

  localparam int FB_WIDTH    = 128;
  localparam int FB_HEIGHT   = 64;
  localparam int FB_BYTES    = FB_WIDTH * ((FB_HEIGHT + 7) / 8);
  localparam int RIGHT_LIMIT = FB_WIDTH - 6;
  localparam int CHAR_PITCH  = 6;
  localparam int FIRST_CODE  = 32;
  localparam int LAST_CODE   = 126;
  localparam int FALLBACK    = 63;

  localparam int FONT_COLUMNS [95][5] = '{
    '{0,0,0,0,0},'{0,0,95,0,0},'{0,7,0,7,0},'{20,127,20,127,20},
    '{36,42,127,42,18},'{35,19,8,100,98},'{54,73,85,34,80},'{0,0,7,0,0},
    '{0,28,34,65,0},'{0,65,34,28,0},'{20,8,62,8,20},'{8,8,62,8,8},
    '{0,80,48,0,0},'{8,8,8,8,8},'{0,96,96,0,0},'{32,16,8,4,2},
    '{62,81,73,69,62},'{0,66,127,64,0},'{66,97,81,73,70},'{33,65,69,75,49},
    '{24,20,18,127,16},'{39,69,69,69,57},'{60,74,73,73,48},'{1,113,9,5,3},
    '{54,73,73,73,54},'{6,73,73,41,30},'{0,54,54,0,0},'{0,86,54,0,0},
    '{8,20,34,65,0},'{20,20,20,20,20},'{65,34,20,8,0},'{2,1,81,9,6},
    '{50,73,121,65,62},'{126,17,17,17,126},'{127,73,73,73,54},'{62,65,65,65,34},
    '{127,65,65,34,28},'{127,73,73,65,65},'{127,9,9,1,1},'{62,65,73,73,122},
    '{127,8,8,8,127},'{0,65,127,65,0},'{32,64,65,63,1},'{127,8,20,34,65},
    '{127,64,64,64,64},'{127,2,12,2,127},'{127,4,8,16,127},'{62,65,65,65,62},
    '{127,9,9,9,6},'{62,65,81,33,94},'{127,9,25,41,70},'{38,73,73,73,50},
    '{1,1,127,1,1},'{63,64,64,64,63},'{31,32,64,32,31},'{127,32,24,32,127},
    '{99,20,8,20,99},'{3,4,120,4,3},'{97,81,73,69,67},'{0,127,65,65,0},
    '{2,4,8,16,32},'{0,65,65,127,0},'{4,2,1,2,4},'{64,64,64,64,64},
    '{0,3,7,0,0},'{32,84,84,84,120},'{127,72,68,68,56},'{56,68,68,68,32},
    '{56,68,68,72,127},'{56,84,84,84,24},'{8,126,9,1,2},'{12,82,82,82,62},
    '{127,8,4,4,120},'{0,68,125,64,0},'{32,64,68,61,0},'{127,16,40,68,0},
    '{0,65,127,64,0},'{124,4,24,4,120},'{124,8,4,4,120},'{56,68,68,68,56},
    '{124,20,20,20,8},'{8,20,20,24,124},'{124,8,4,4,8},'{72,84,84,84,36},
    '{4,63,68,64,32},'{60,64,64,32,124},'{28,32,64,32,28},'{60,64,48,64,60},
    '{68,40,16,40,68},'{12,80,80,80,60},'{68,100,84,76,68},'{0,8,54,65,0},
    '{0,0,127,0,0},'{0,65,54,8,0},'{8,4,8,16,8}
  };

  typedef struct {
    logic [7:0] pixel_byte;
    logic [9:0] read_index;
  } page_read_t;

  logic [7:0]  frame_bytes [FB_BYTES];
  logic [7:0]  cursor_col;
  logic [7:0]  cursor_row;
  logic        text_open;
  page_read_t  pending_reads [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    action_t    act;
    logic [7:0] code;
    logic [7:0] col_bits;
    logic [9:0] idx;
    page_read_t got;
    page_read_t want;
    int         glyph;
    int         px;
    int         py;

    if (!rst_n) begin
      foreach (frame_bytes[i]) frame_bytes[i] = '0;
      cursor_col = '0;
      cursor_row = '0;
      text_open  = 1'b0;
      pending_reads.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.pixel_byte = out_tdata[7:0];
        got.read_index = out_tdata[17:8];
        if (pending_reads.size() == 0) begin
          report_mismatch($sformatf("read result idx %0d with no read outstanding",
                                    got.read_index));
        end else begin
          want = pending_reads.pop_front();
          if (got.pixel_byte !== want.pixel_byte) begin
            report_mismatch($sformatf("pixel_byte at idx %0d: got %02h want %02h",
                                      want.read_index, got.pixel_byte, want.pixel_byte));
          end
          if (got.read_index !== want.read_index) begin
            report_mismatch($sformatf("read_index: got %0d want %0d",
                                      got.read_index, want.read_index));
          end
        end
      end

      if (in_tvalid && in_tready) begin
        act  = action_t'(in_tdata[1:0]);
        code = in_tdata[25:18];
        idx  = in_tdata[35:26];
        case (act)
          ACT_CLEAR: begin
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
          end
          ACT_START: begin
            cursor_col = in_tdata[9:2];
            cursor_row = in_tdata[17:10];
            text_open  = 1'b1;
          end
          ACT_CHAR: begin
            if (text_open) begin
              if (code == 8'd0 || int'(cursor_col) > RIGHT_LIMIT) begin
                text_open = 1'b0;
              end else begin
                glyph = (code < FIRST_CODE || code > LAST_CODE) ? FALLBACK : int'(code);
                for (int c = 0; c < 5; c++) begin
                  col_bits = 8'(FONT_COLUMNS[glyph - FIRST_CODE][c]);
                  for (int r = 0; r < 7; r++) begin
                    px = int'(cursor_col) + c;
                    py = int'(cursor_row) + r;
                    if (col_bits[r] && px < FB_WIDTH && py < FB_HEIGHT) begin
                      frame_bytes[(py / 8) * FB_WIDTH + px][py % 8] = 1'b1;
                    end
                  end
                end
                cursor_col = cursor_col + 8'(CHAR_PITCH);
              end
            end
          end
          default: begin
            want.pixel_byte = (int'(idx) < FB_BYTES) ? frame_bytes[idx] : 8'd0;
            want.read_index = idx;
            pending_reads.push_back(want);
          end
        endcase
      end
    end
    pending = pending_reads.size();
  end

endmodule

### tb/text_glyph_framebuffer_renderer_tb.sv
// Testbench top: clock, reset, command stimulus with random idling, watchdog and verdict.
module text_glyph_framebuffer_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tgfr_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 1100;
  localparam int TARGET      = 1400;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int   mismatches;
  int   pending;
  int   quiet_cycles = 0;
  int   sent = 0;
  logic steady = 1'b0;

  always #10ns clk = ~clk;

  text_glyph_framebuffer_renderer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  tgfr_render_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send(action_t act, logic [7:0] sx, logic [7:0] sy, logic [7:0] ch,
                      logic [9:0] idx);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {4'b0, idx, ch, sy, sx, act};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic read_byte(logic [9:0] idx);
    send(ACT_READ, 8'($urandom), 8'($urandom), 8'($urandom), idx);
  endtask

  task automatic open_text(logic [7:0] x, logic [7:0] y);
    send(ACT_START, x, y, 8'($urandom), 10'($urandom));
  endtask

  task automatic put_char(logic [7:0] ch);
    send(ACT_CHAR, 8'($urandom), 8'($urandom), ch, 10'($urandom));
  endtask

  task automatic wipe();
    send(ACT_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 10'($urandom));
  endtask

  // hold the sender until every outstanding read has returned
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(32, 126));
    if (r < 97) return 8'($urandom_range(1, 255));
    return 8'd0;
  endfunction

  initial begin : stimulus
    logic [7:0] x;
    logic [7:0] y;
    int         len;
    int         kind;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    read_byte(10'd0);
    read_byte(10'd1023);
    put_char(8'd65);
    open_text(8'd0, 8'd0);
    put_char(8'd65);
    put_char(8'd32);
    put_char(8'd126);
    put_char(8'd31);
    put_char(8'd127);
    put_char(8'd255);
    read_byte(10'd0);
    read_byte(10'd27);
    open_text(8'd122, 8'd60);
    put_char(8'd87);
    put_char(8'd88);
    put_char(8'd89);
    read_byte(10'd1018);
    open_text(8'd255, 8'd255);
    put_char(8'd66);
    open_text(8'd10, 8'd3);
    put_char(8'd72);
    put_char(8'd0);
    put_char(8'd67);
    read_byte(10'd10);
    read_byte(10'd138);
    wipe();
    read_byte(10'd0);
    settle();

    while (sent < TARGET) begin
      steady = ($urandom_range(0, 4) == 0);
      kind   = $urandom_range(0, 99);
      if (kind < 70) begin
        x   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 122));
        y   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63));
        len = $urandom_range(1, 22);
        open_text(x, y);
        repeat (len) put_char(pick_char());
        repeat ($urandom_range(3, 10)) begin
          read_byte(10'(((y / 8 + $urandom_range(0, 1)) % 8) * 128 +
                        (x + $urandom_range(0, len * 6)) % 128));
        end
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 6)) read_byte(10'($urandom_range(0, 1023)));
      end else if (kind < 96) begin
        put_char(8'($urandom));
      end else begin
        wipe();
        read_byte(10'($urandom_range(0, 1023)));
      end
      if ($urandom_range(0, 39) == 0) settle();
    end

    steady = 1'b0;
    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
